>>> hw/rtl/tsfd_pkg.sv
// ----------------------------------------------------------------------------
// tsfd_pkg
// Shared types and constants of the typed serial frame deframer.
// ----------------------------------------------------------------------------
package tsfd_pkg;

  parameter int unsigned MAX_FRAME_DEF = 64;

  // wide enough for any frame length of the supported range (up to 256)
  parameter int unsigned LEN_W = 9;
  parameter int unsigned CMD_DEPTH = 2;

  parameter logic [LEN_W-1:0] MIN_LEN = LEN_W'(4);

  typedef enum logic [2:0] {
    CFG_HEADER     = 3'd0,
    CFG_TAIL       = 3'd1,
    CFG_SENSOR     = 3'd2,
    CFG_TIMING     = 3'd3,
    CFG_SENSOR_LEN = 3'd4,
    CFG_TIMING_LEN = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_PAYLOAD  = 2'd0,
    ST_BAD_TAIL = 2'd1,
    ST_BAD_SUM  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_CODE = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_HOLD = 2'd2
  } back_state_e;

  typedef struct packed {
    status_e          status;
    logic             kind;
    logic             bank;
    logic [LEN_W-1:0] plen;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

endpackage

>>> hw/rtl/tsfd_front.sv
// ----------------------------------------------------------------------------
// tsfd_front
// Byte parser: header hunt, code decode, payload capture and frame check.
// ----------------------------------------------------------------------------
module tsfd_front #(
  parameter int unsigned MaxFrame = tsfd_pkg::MAX_FRAME_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [2:0]                   cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [7:0]                   s_tdata_i,
  output logic                         cmd_valid_o,
  output tsfd_pkg::cmd_t               cmd_o,
  input  logic                         cmd_full_i,
  input  tsfd_pkg::done_t              done_i,
  output logic                         mem_we_o,
  output logic [$clog2(MaxFrame):0]    mem_waddr_o,
  output logic [7:0]                   mem_wdata_o
);
  import tsfd_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxFrame);
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MaxFrame);

  logic [7:0] header_q, tail_q, sensor_q, timing_q;
  logic [6:0] sensor_len_q, timing_len_q;

  phase_e           phase_q, phase_d;
  logic             kind_q, kind_d;
  logic [LEN_W-1:0] exp_len_q, exp_len_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       sum_q, sum_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;

  logic             acc;
  logic             sel_timing;
  logic [LEN_W-1:0] raw_len, clamp_len;
  logic [LEN_W-1:0] pos;

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = !cmd_full_i && !busy_q[bank_q];
  assign acc         = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q     <= 8'hFC;
      tail_q       <= 8'hDF;
      sensor_q     <= 8'h20;
      timing_q     <= 8'h10;
      sensor_len_q <= 7'd38;
      timing_len_q <= 7'd20;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HEADER:     header_q     <= cfg_data_i;
        CFG_TAIL:       tail_q       <= cfg_data_i;
        CFG_SENSOR:     sensor_q     <= cfg_data_i;
        CFG_TIMING:     timing_q     <= cfg_data_i;
        CFG_SENSOR_LEN: sensor_len_q <= cfg_data_i[6:0];
        CFG_TIMING_LEN: timing_len_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // sensor code wins when both codes match
  assign sel_timing = (s_tdata_i != sensor_q);
  assign raw_len    = LEN_W'(sel_timing ? timing_len_q : sensor_len_q);
  assign clamp_len  = (raw_len < MIN_LEN) ? MIN_LEN :
                      (raw_len > MaxLen)  ? MaxLen  : raw_len;
  assign pos        = cnt_q - LEN_W'(2);

  always_comb begin
    phase_d     = phase_q;
    kind_d      = kind_q;
    exp_len_d   = exp_len_q;
    cnt_d       = cnt_q;
    xor_d       = xor_q;
    sum_d       = sum_q;
    bank_d      = bank_q;
    busy_d      = busy_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '{status: ST_PAYLOAD, kind: kind_q, bank: bank_q,
                    plen: exp_len_q - MIN_LEN};
    mem_we_o    = 1'b0;
    mem_waddr_o = {bank_q, pos[IdxW-1:0]};
    mem_wdata_o = s_tdata_i;

    if (done_i.valid) begin
      busy_d[done_i.bank] = 1'b0;
    end

    if (acc) begin
      case (phase_q)
        PH_CODE: begin
          if (s_tdata_i == sensor_q || s_tdata_i == timing_q) begin
            kind_d    = sel_timing;
            exp_len_d = clamp_len;
            xor_d     = xor_q ^ s_tdata_i;
            cnt_d     = LEN_W'(2);
            phase_d   = PH_BODY;
          end else if (s_tdata_i == header_q) begin
            xor_d = s_tdata_i;
            cnt_d = LEN_W'(1);
          end else begin
            phase_d = PH_HUNT;
            cnt_d   = '0;
          end
        end
        PH_BODY: begin
          if (cnt_q < exp_len_q - LEN_W'(2)) begin
            mem_we_o = 1'b1;
            xor_d    = xor_q ^ s_tdata_i;
            cnt_d    = cnt_q + LEN_W'(1);
          end else if (cnt_q == exp_len_q - LEN_W'(2)) begin
            sum_d = s_tdata_i;
            cnt_d = cnt_q + LEN_W'(1);
          end else begin
            if (s_tdata_i != tail_q) begin
              cmd_o.status = ST_BAD_TAIL;
              cmd_valid_o  = 1'b1;
            end else if (sum_q != xor_q) begin
              cmd_o.status = ST_BAD_SUM;
              cmd_valid_o  = 1'b1;
            end else if (exp_len_q != MIN_LEN) begin
              cmd_valid_o    = 1'b1;
              busy_d[bank_q] = 1'b1;
              bank_d         = !bank_q;
            end
            phase_d = PH_HUNT;
            cnt_d   = '0;
          end
        end
        default: begin
          if (s_tdata_i == header_q) begin
            phase_d = PH_CODE;
            xor_d   = s_tdata_i;
            cnt_d   = LEN_W'(1);
          end else begin
            phase_d = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      kind_q    <= 1'b0;
      exp_len_q <= '0;
      cnt_q     <= '0;
      xor_q     <= '0;
      sum_q     <= '0;
      bank_q    <= 1'b0;
      busy_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      exp_len_q <= exp_len_d;
      cnt_q     <= cnt_d;
      xor_q     <= xor_d;
      sum_q     <= sum_d;
      bank_q    <= bank_d;
      busy_q    <= busy_d;
    end
  end

endmodule

>>> hw/rtl/tsfd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tsfd_cmd_fifo
// Short frame command queue between the parser and the replay side.
// ----------------------------------------------------------------------------
module tsfd_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tsfd_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tsfd_pkg::cmd_t head_o
);
  import tsfd_pkg::*;

  localparam int unsigned PtrW = $clog2(CMD_DEPTH);
  localparam int unsigned CntW = $clog2(CMD_DEPTH + 1);

  cmd_t            mem_q [CMD_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(CMD_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/tsfd_back.sv
// ----------------------------------------------------------------------------
// tsfd_back
// Replay side: payload store, result sequencer and output register.
// ----------------------------------------------------------------------------
module tsfd_back #(
  parameter int unsigned MaxFrame = tsfd_pkg::MAX_FRAME_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      mem_we_i,
  input  logic [$clog2(MaxFrame):0] mem_waddr_i,
  input  logic [7:0]                mem_wdata_i,
  input  logic                      cmd_valid_i,
  input  tsfd_pkg::cmd_t            cmd_i,
  output logic                      cmd_pop_o,
  output tsfd_pkg::done_t           done_o,
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  output logic [15:0]               m_tdata_o,  // payload_byte, byte_index, zero fill
  output logic [2:0]                m_tuser_o,  // status, frame_kind
  output logic                      m_tlast_o
);
  import tsfd_pkg::*;

  localparam int unsigned IdxW  = $clog2(MaxFrame);
  localparam int unsigned Depth = 2 ** (IdxW + 1);

  logic [7:0] mem [Depth];
  logic [7:0] rd_q;
  logic [IdxW:0] raddr;

  back_state_e     state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] idx_nxt;

  logic       valid_q, valid_d;
  status_e    st_q, st_d;
  logic       kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic [5:0] index_q, index_d;
  logic       last_q, last_d;

  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem[mem_waddr_i] <= mem_wdata_i;
    end
    rd_q <= mem[raddr];
  end

  assign idx_nxt = idx_q + IdxW'(1);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    valid_d   = valid_q;
    st_d      = st_q;
    kind_d    = kind_q;
    byte_d    = byte_q;
    index_d   = index_q;
    last_d    = last_q;
    cmd_pop_o = 1'b0;
    done_o    = '{valid: 1'b0, bank: cmd_q.bank};
    raddr     = {cmd_q.bank, idx_nxt};

    case (state_q)
      BK_IDLE: begin
        raddr = {cmd_i.bank, {IdxW{1'b0}}};
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          if (cmd_i.status != ST_PAYLOAD) begin
            valid_d = 1'b1;
            st_d    = cmd_i.status;
            kind_d  = cmd_i.kind;
            byte_d  = '0;
            index_d = '0;
            last_d  = 1'b1;
            state_d = BK_HOLD;
          end else begin
            state_d = BK_READ;
          end
        end
      end
      BK_READ: begin
        valid_d = 1'b1;
        st_d    = ST_PAYLOAD;
        kind_d  = cmd_q.kind;
        byte_d  = rd_q;
        index_d = 6'(idx_q);
        last_d  = (LEN_W'(idx_q) + LEN_W'(1)) == cmd_q.plen;
        state_d = BK_HOLD;
      end
      BK_HOLD: begin
        if (m_tready_i) begin
          valid_d = 1'b0;
          if (last_q) begin
            done_o.valid = (cmd_q.status == ST_PAYLOAD);
            state_d      = BK_IDLE;
          end else begin
            idx_d   = idx_nxt;
            state_d = BK_READ;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    st_q    <= st_d;
    kind_q  <= kind_d;
    byte_q  <= byte_d;
    index_q <= index_d;
    last_q  <= last_d;
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {2'b00, index_q, byte_q};
  assign m_tuser_o  = {kind_q, st_q};
  assign m_tlast_o  = last_q;

endmodule

>>> hw/rtl/typed_serial_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// typed_serial_frame_deframer_core
// Header/tail serial frame parser with XOR check and payload replay.
// ----------------------------------------------------------------------------
// Received bytes enter on the s_axis channel, one byte per word. The parser
// hunts for the header, decodes the function code into a sensor or time sync
// frame, stores the payload and checks the tail and the XOR checksum.
// Results leave on the m_axis channel: a good frame replays its payload bytes
// with tlast on the final one, a bad frame gives a single status word.
// The cfg channel writes the six frame registers by index; it is always ready.
// Input: one byte per cycle. s_axis_tready_o drops while the two-entry frame
// queue is full or while the payload buffer the parser would fill next still
// awaits replay (two buffers alternate between frames).
// With the replay side idle, the first result word passes the frame queue and
// the output register once the tail byte is taken; payload words also pass
// the registered store read. Output: payload words never come back to back;
// a stalled receiver holds the word and the parser keeps running until its
// queue or both buffers fill.
// Reset returns the parser to header hunt, empties the queue and restores the
// register defaults; the payload store is not cleared.
// ----------------------------------------------------------------------------
module typed_serial_frame_deframer_core #(
  parameter int unsigned MaxFrame = tsfd_pkg::MAX_FRAME_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // payload_byte, byte_index, zero fill
  output logic [2:0]  m_axis_tuser_o,   // status, frame_kind
  output logic        m_axis_tlast_o
);
  import tsfd_pkg::*;

  cmd_t  push_cmd, head_cmd;
  done_t done;
  logic  push, full, head_valid, pop;
  logic  mem_we;
  logic [$clog2(MaxFrame):0] mem_waddr;
  logic [7:0] mem_wdata;

  tsfd_front #(.MaxFrame(MaxFrame)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .cmd_valid_o (push),
    .cmd_o       (push_cmd),
    .cmd_full_i  (full),
    .done_i      (done),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  tsfd_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head_cmd)
  );

  tsfd_back #(.MaxFrame(MaxFrame)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mem_we_i    (mem_we),
    .mem_waddr_i (mem_waddr),
    .mem_wdata_i (mem_wdata),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .done_o      (done),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

endmodule

>>> hw/rtl/tsfd_checker.sv
// ----------------------------------------------------------------------------
// tsfd_checker
// Port-level checks of the deframer output stream.
// ----------------------------------------------------------------------------
module tsfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import tsfd_pkg::*;

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("stalled output word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[1:0] != ST_PAYLOAD) |->
      m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("error word not last or not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[1:0] == ST_PAYLOAD) ||
      (m_axis_tuser_o[1:0] == ST_BAD_TAIL) || (m_axis_tuser_o[1:0] == ST_BAD_SUM))
    else $error("undefined status code");

  // a word is never followed by another one in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i |=> !m_axis_tvalid_o)
    else $error("result words closer than two cycles");

  // kind stays fixed within a run of payload words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      ##1 (!m_axis_tvalid_o || (m_axis_tuser_o[2] == $past(m_axis_tuser_o[2], 2))))
    else $error("frame kind changed within a frame");

endmodule

bind typed_serial_frame_deframer_core tsfd_checker u_tsfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> tb/tb_typed_serial_frame_deframer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_typed_serial_frame_deframer_core
// Self-checking bench for the typed serial frame deframer.
// ----------------------------------------------------------------------------
// Streams header/code/payload/checksum/tail byte frames into the parser and
// compares every result word with a frame predictor kept in a scoreboard.
// Directed frames cover reset defaults, both frame kinds, bad tail, bad sum,
// unknown codes, header retry, equal codes, empty and longest payloads and
// clamped lengths. Random register settings then carry mostly well-formed
// frames mixed with noise and broken frames. Both sides idle at random, and
// one long receiver hold-off lets the parser fill up and stall its input.
// ----------------------------------------------------------------------------
module tb_typed_serial_frame_deframer_core;
  import tsfd_pkg::*;

  localparam int unsigned FRAME_MAX    = MAX_FRAME_DEF;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TIMEOUT_NS   = 2_000_000;

  typedef struct packed {
    status_e    status;
    logic       kind;
    logic [7:0] value;
    logic [5:0] index;
    logic       last;
  } out_word_t;

  typedef enum int {
    FAULT_NONE,
    FAULT_TAIL,
    FAULT_SUM,
    FAULT_BOTH
  } frame_fault_e;

  class frame_scoreboard;
    logic [7:0]  header, tail, sensor_code, timing_code;
    logic [6:0]  sensor_len, timing_len;
    phase_e      phase;
    logic        kind;
    int unsigned exp_len, count;
    logic [7:0]  xsum, held_sum;
    logic [7:0]  payload [FRAME_MAX];
    out_word_t   expected_q[$];
    int unsigned mismatches, words, good_frames, error_words, bytes;

    function new();
      header      = 8'hFC;
      tail        = 8'hDF;
      sensor_code = 8'h20;
      timing_code = 8'h10;
      sensor_len  = 7'd38;
      timing_len  = 7'd20;
      phase       = PH_HUNT;
      kind        = 1'b0;
      exp_len     = 0;
      count       = 0;
      xsum        = '0;
      held_sum    = '0;
    endfunction

    function int unsigned clamp_len(logic [6:0] v);
      if (v < 4) return 4;
      if (v > FRAME_MAX) return FRAME_MAX;
      return v;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [7:0] d);
      case (idx)
        CFG_HEADER:     header      = d;
        CFG_TAIL:       tail        = d;
        CFG_SENSOR:     sensor_code = d;
        CFG_TIMING:     timing_code = d;
        CFG_SENSOR_LEN: sensor_len  = d[6:0];
        CFG_TIMING_LEN: timing_len  = d[6:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      out_word_t   w;
      int unsigned i;
      bytes++;
      case (phase)
        PH_CODE: begin
          if (b == sensor_code || b == timing_code) begin
            kind    = (b != sensor_code);
            exp_len = clamp_len(kind ? timing_len : sensor_len);
            xsum    = xsum ^ b;
            count   = 2;
            phase   = PH_BODY;
          end else if (b == header) begin
            // code byte retried as a new header
            xsum  = b;
            count = 1;
          end else begin
            phase = PH_HUNT;
            count = 0;
          end
        end
        PH_BODY: begin
          if (count < exp_len - 2) begin
            payload[count - 2] = b;
            xsum  = xsum ^ b;
            count++;
          end else if (count == exp_len - 2) begin
            held_sum = b;
            count++;
          end else begin
            w.kind  = kind;
            w.value = '0;
            w.index = '0;
            w.last  = 1'b1;
            if (b != tail) begin
              w.status = ST_BAD_TAIL;
              expected_q.insert(expected_q.size(), w);
            end else if (held_sum != xsum) begin
              w.status = ST_BAD_SUM;
              expected_q.insert(expected_q.size(), w);
            end else begin
              for (i = 0; i < exp_len - 4; i++) begin
                w.status = ST_PAYLOAD;
                w.value  = payload[i];
                w.index  = 6'(i);
                w.last   = (i + 1 == exp_len - 4);
                expected_q.insert(expected_q.size(), w);
              end
            end
            phase = PH_HUNT;
            count = 0;
          end
        end
        default: begin
          if (b == header) begin
            phase = PH_CODE;
            xsum  = b;
            count = 1;
          end else begin
            phase = PH_HUNT;
          end
        end
      endcase
    endfunction

    function void check_word(logic [15:0] data, logic [2:0] user, logic last);
      out_word_t got, want;
      got.status = status_e'(user[1:0]);
      got.kind   = user[2];
      got.value  = data[7:0];
      got.index  = data[13:8];
      got.last   = last;
      words++;
      if (got.status == ST_PAYLOAD) begin
        if (got.last) good_frames++;
      end else begin
        error_words++;
      end
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: st=%0d kind=%0d byte=%02h idx=%0d last=%0d",
                   got.status, got.kind, got.value, got.index, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.kind !== want.kind ||
          got.value !== want.value || got.index !== want.index ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("word mismatch: expected st=%0d kind=%0d byte=%02h idx=%0d last=%0d",
                   want.status, want.kind, want.value, want.index, want.last);
          $display("               got      st=%0d kind=%0d byte=%02h idx=%0d last=%0d",
                   got.status, got.kind, got.value, got.index, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // rx_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;   // payload_byte, byte_index, zero fill
  logic [2:0]  m_axis_tuser_o;   // status, frame_kind
  logic        m_axis_tlast_o;

  frame_scoreboard sb = new();
  logic [7:0]      stream_q[$];
  bit              tx_quiet, rx_quiet, hold_req;
  int unsigned     settings;

  typed_serial_frame_deframer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_typed_serial_frame_deframer_core: FAIL");
    $finish;
  end

  // result words are checked before the same edge's input word is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_word(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_byte(s_axis_tdata_i);
    end
  end

  // receiver with random stalls and one long hold-off on request
  initial begin
    int unsigned stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  function automatic void stage_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
  endtask

  task automatic flush_stream();
    while (stream_q.size() > 0) send_byte(stream_q.pop_front());
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [7:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    sb.write_reg(idx, d);
  endtask

  task automatic apply_config(input logic [7:0] hdr, input logic [7:0] tl,
                              input logic [7:0] sc, input logic [7:0] tc,
                              input logic [6:0] sl, input logic [6:0] tlen);
    settle();
    cfg_write(CFG_HEADER, hdr);
    cfg_write(CFG_TAIL, tl);
    cfg_write(CFG_SENSOR, sc);
    cfg_write(CFG_TIMING, tc);
    cfg_write(CFG_SENSOR_LEN, {1'b0, sl});
    cfg_write(CFG_TIMING_LEN, {1'b0, tlen});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    settings++;
  endtask

  task automatic random_config();
    logic [7:0] sc;
    sc = 8'($urandom);
    apply_config(8'($urandom), 8'($urandom), sc,
                 ($urandom_range(0, 7) == 0) ? sc : 8'($urandom),
                 7'($urandom_range(1, 16)), 7'($urandom_range(1, 16)));
  endtask

  // header, code, payload, checksum, tail; equal codes give a sensor frame
  task automatic push_frame(input bit use_timing, input frame_fault_e fault,
                            input bit extreme = 1'b0);
    logic [7:0]  code, sum, v;
    int unsigned len, i;
    code = use_timing ? sb.timing_code : sb.sensor_code;
    len  = sb.clamp_len((code == sb.sensor_code) ? sb.sensor_len : sb.timing_len);
    sum  = sb.header ^ code;
    stage_byte(sb.header);
    stage_byte(code);
    for (i = 0; i < len - 4; i++) begin
      v = extreme ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
      sum = sum ^ v;
      stage_byte(v);
    end
    if (fault == FAULT_SUM || fault == FAULT_BOTH)
      sum = sum ^ 8'($urandom_range(1, 255));
    stage_byte(sum);
    if (fault == FAULT_TAIL || fault == FAULT_BOTH)
      stage_byte(sb.tail ^ 8'($urandom_range(1, 255)));
    else
      stage_byte(sb.tail);
  endtask

  task automatic push_unknown_code();
    logic [7:0] c;
    do c = 8'($urandom); while (c == sb.sensor_code || c == sb.timing_code);
    stage_byte(sb.header);
    stage_byte(c);
  endtask

  task automatic random_traffic(input int unsigned budget);
    int unsigned r, k;
    while (stream_q.size() < budget) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        push_frame(1'($urandom_range(0, 1)), FAULT_NONE);
      end else if (r < 78) begin
        push_frame(1'($urandom_range(0, 1)), FAULT_TAIL);
      end else if (r < 84) begin
        push_frame(1'($urandom_range(0, 1)), FAULT_SUM);
      end else if (r < 87) begin
        push_frame(1'($urandom_range(0, 1)), FAULT_BOTH);
      end else if (r < 92) begin
        push_unknown_code();
      end else if (r < 96) begin
        repeat ($urandom_range(1, 3)) stage_byte(8'($urandom));
      end else begin
        // truncated frame: the next frame's bytes land in its body
        stage_byte(sb.header);
        stage_byte($urandom_range(0, 1) ? sb.timing_code : sb.sensor_code);
        k = $urandom_range(0, 3);
        repeat (k) stage_byte(8'($urandom));
      end
    end
    flush_stream();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_HEADER;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    tx_quiet        = 1'b0;
    rx_quiet        = 1'b0;
    hold_req        = 1'b0;
    settings        = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults
    push_frame(1'b1, FAULT_NONE);
    push_frame(1'b0, FAULT_SUM);
    flush_stream();

    // every status, both kinds, empty payload, unknown code, header retry
    apply_config(8'hFC, 8'hDF, 8'h20, 8'h10, 7'd6, 7'd4);
    push_frame(1'b0, FAULT_NONE, 1'b1);
    push_frame(1'b1, FAULT_NONE);
    push_frame(1'b0, FAULT_TAIL);
    push_frame(1'b1, FAULT_SUM);
    push_frame(1'b0, FAULT_BOTH);
    push_unknown_code();
    push_frame(1'b0, FAULT_NONE);
    stage_byte(sb.header);
    push_frame(1'b0, FAULT_NONE);
    stage_byte(8'h00);
    stage_byte(8'hFF);
    push_frame(1'b0, FAULT_NONE);
    flush_stream();

    // extreme register values, short length raised to the minimum
    apply_config(8'h00, 8'hFF, 8'hFF, 8'h00, 7'd1, 7'd4);
    push_frame(1'b0, FAULT_NONE);
    push_frame(1'b1, FAULT_NONE);
    push_frame(1'b1, FAULT_SUM);
    flush_stream();

    // equal codes, long length cut to the longest payload
    apply_config(8'hFF, 8'h00, 8'h7E, 8'h7E, 7'd100, 7'd1);
    push_frame(1'b1, FAULT_NONE, 1'b1);
    flush_stream();

    // back-to-back frames against a stalled receiver
    apply_config(8'hA5, 8'h5A, 8'h3C, 8'hC3, 7'd8, 7'd10);
    tx_quiet = 1'b1;
    hold_req = 1'b1;
    repeat (6) push_frame(1'($urandom_range(0, 1)), FAULT_NONE);
    flush_stream();
    tx_quiet = 1'b0;

    repeat (2) begin
      random_config();
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      random_traffic(16);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    settle();

    $display("covered %0d bytes over %0d register settings plus reset defaults",
             sb.bytes, settings);
    $display("checked %0d words: %0d good frames replayed, %0d error words",
             sb.words, sb.good_frames, sb.error_words);
    if (sb.mismatches == 0) begin
      $display("tb_typed_serial_frame_deframer_core: PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb_typed_serial_frame_deframer_core: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/tsfd_pkg.sv
hw/rtl/tsfd_front.sv
hw/rtl/tsfd_cmd_fifo.sv
hw/rtl/tsfd_back.sv
hw/rtl/typed_serial_frame_deframer_core.sv
hw/rtl/tsfd_checker.sv
tb/tb_typed_serial_frame_deframer_core.sv
